// ----- sv/bpt_pkg.sv -----
// bpt_pkg: shared types, codes and reset constants for the perceptron trainer
// no dependencies; imported by binary_perceptron_trainer_core
package bpt_pkg;

    // default configuration of the neuron
    localparam int BPT_N_INPUTS    = 9;
    localparam int BPT_WEIGHT_BITS = 16;

    // fixed field widths
    localparam int PIXEL_BITS   = 9;
    localparam int LABEL_BITS   = 4;
    localparam int INDEX_BITS   = 4;
    localparam int WVAL_BITS    = 16;
    localparam int THR_BITS     = 20;
    localparam int SUM_OUT_BITS = 20;
    localparam int COUNT_BITS   = 16;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 20;

    // reset values of the configuration registers
    localparam logic signed [THR_BITS-1:0]   THRESHOLD_RST    = 20'sd35;
    localparam logic        [LABEL_BITS-1:0] TARGET_CLASS_RST = 4'd4;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_THRESHOLD    = 1'b0,
        REG_TARGET_CLASS = 1'b1
    } cfg_reg_t;

    // request operation codes
    typedef enum logic [1:0] {
        OP_TRAIN = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    // one captured request
    typedef struct packed {
        op_t                          op;
        logic [PIXEL_BITS-1:0]        pixels;
        logic [LABEL_BITS-1:0]        label;
        logic [INDEX_BITS-1:0]        weight_index;
        logic signed [WVAL_BITS-1:0]  weight_value;
        logic                         clear_counts;
    } item_t;

    // weight values after reset; inputs past the seventh start at zero
    function automatic logic signed [31:0] reset_weight(input int k);
        logic signed [31:0] w;
        case (k)
            0:       w = 32'sd8;
            1:       w = 32'sd7;
            2:       w = 32'sd0;
            3:       w = 32'sd3;
            4:       w = -32'sd9;
            5:       w = 32'sd3;
            6:       w = 32'sd7;
            default: w = 32'sd0;
        endcase
        return w;
    endfunction

endpackage

// ----- sv/binary_perceptron_trainer_core.sv -----
// binary_perceptron_trainer_core: single-neuron perceptron with online training
// depends on bpt_pkg (codes, request struct, reset weights)
// path: an accepted request is held in the request register, then its result in the result register
// throughput: one request per cycle unless the result channel stalls; the weights written
//   by a training request are seen by the very next request, since the whole sum, compare
//   and update runs combinationally between the request register and the result register
// reset: async active low; weights, counters and configuration take their reset values
module binary_perceptron_trainer_core
    import bpt_pkg::*;
#(
    parameter int N_INPUTS    = BPT_N_INPUTS,
    parameter int WEIGHT_BITS = BPT_WEIGHT_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [CFG_DATA_BITS-1:0]        cfg_wdata,

    // request channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      op,
    input  logic [PIXEL_BITS-1:0]           pixels,
    input  logic [LABEL_BITS-1:0]           label,
    input  logic [INDEX_BITS-1:0]           weight_index,
    input  logic signed [WVAL_BITS-1:0]     weight_value,
    input  logic                            clear_counts,

    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [SUM_OUT_BITS-1:0]  weighted_sum,
    output logic                            fired,
    output logic                            correct,
    output logic                            updated,
    output logic [COUNT_BITS-1:0]           match_total,
    output logic [COUNT_BITS-1:0]           change_total,
    output logic signed [WVAL_BITS-1:0]     weight_out
);

    // exact sum width and the width the threshold compare runs at
    localparam int SUM_BITS = WEIGHT_BITS + $clog2(N_INPUTS);
    localparam int CMP_BITS = (SUM_BITS > THR_BITS) ? SUM_BITS : THR_BITS;
    // pixel vector widened to the neuron's input count where that is larger
    localparam int PIX_BITS = (N_INPUTS > PIXEL_BITS) ? N_INPUTS : PIXEL_BITS;
    localparam int WIDE_BITS = 33;

    localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
    localparam logic signed [WIDE_BITS-1:0] W_MAX_W = WIDE_BITS'(W_MAX);
    localparam logic signed [WIDE_BITS-1:0] W_MIN_W = WIDE_BITS'(W_MIN);
    localparam logic signed [WIDE_BITS-1:0] RD_MAX_W =
        WIDE_BITS'((64'sd1 <<< (WVAL_BITS - 1)) - 64'sd1);
    localparam logic signed [WIDE_BITS-1:0] RD_MIN_W =
        WIDE_BITS'(-(64'sd1 <<< (WVAL_BITS - 1)));
    localparam logic signed [CMP_BITS-1:0] SUM_MAX_C =
        CMP_BITS'((64'sd1 <<< (SUM_OUT_BITS - 1)) - 64'sd1);
    localparam logic signed [CMP_BITS-1:0] SUM_MIN_C =
        CMP_BITS'(-(64'sd1 <<< (SUM_OUT_BITS - 1)));
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // configuration registers
    logic signed [THR_BITS-1:0]     threshold_reg;
    logic [LABEL_BITS-1:0]          target_class_reg;

    // neuron state
    logic signed [WEIGHT_BITS-1:0]  weight_reg [N_INPUTS];
    logic signed [WEIGHT_BITS-1:0]  weight_next [N_INPUTS];
    logic [COUNT_BITS-1:0]          match_cnt_reg, match_cnt_next;
    logic [COUNT_BITS-1:0]          change_cnt_reg, change_cnt_next;

    // request register stage
    logic                           s1_valid_reg;
    item_t                          s1_item_reg;

    // result register stage
    logic                           out_valid_reg;
    logic signed [SUM_OUT_BITS-1:0] out_sum_reg, out_sum_next;
    logic                           out_fired_reg, out_fired_next;
    logic                           out_correct_reg, out_correct_next;
    logic                           out_updated_reg, out_updated_next;
    logic signed [WVAL_BITS-1:0]    out_wout_reg, out_wout_next;

    // handshake control
    logic                           advance;
    logic                           s1_fire;
    logic                           in_fire;

    // datapath intermediates
    logic [PIX_BITS-1:0]            pix_wide;
    logic signed [SUM_BITS-1:0]     sum;
    logic signed [CMP_BITS-1:0]     sum_c;
    logic signed [CMP_BITS-1:0]     thr_c;
    logic                           fire_now;
    logic                           positive;
    logic                           learn;
    logic                           idx_ok;
    logic signed [WEIGHT_BITS-1:0]  wr_value;
    logic signed [WEIGHT_BITS-1:0]  rd_weight;
    logic signed [WIDE_BITS-1:0]    wval_w;
    logic signed [WIDE_BITS-1:0]    rd_w;
    logic [COUNT_BITS-1:0]          match_base;
    logic [COUNT_BITS-1:0]          change_base;

    // the result register frees up when empty or when its request is taken;
    // the request stage moves on whenever the result register frees up
    assign advance  = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    // configuration registers; the user writes them only when no request is in flight; not enforced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= THRESHOLD_RST;
            target_class_reg <= TARGET_CLASS_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_THRESHOLD:    threshold_reg    <= THR_BITS'(cfg_wdata);
                REG_TARGET_CLASS: target_class_reg <= cfg_wdata[LABEL_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.op           <= op_t'(op);
            s1_item_reg.pixels       <= pixels;
            s1_item_reg.label        <= label;
            s1_item_reg.weight_index <= weight_index;
            s1_item_reg.weight_value <= weight_value;
            s1_item_reg.clear_counts <= clear_counts;
        end
    end

    // weighted sum over the set input bits and the firing decision
    always_comb
    begin
        pix_wide = PIX_BITS'(s1_item_reg.pixels);
        sum      = '0;
        for (int k = 0; k < N_INPUTS; k++)
        begin
            if (pix_wide[k])
            begin
                sum = sum + SUM_BITS'(weight_reg[k]);
            end
        end
        sum_c    = CMP_BITS'(sum);
        thr_c    = CMP_BITS'(threshold_reg);
        fire_now = sum_c > thr_c;
        positive = s1_item_reg.label == target_class_reg;
        // learning rule fires on a miss in either direction
        learn    = fire_now != positive;
    end

    // weight select for reads, write value clipped to the weight range
    always_comb
    begin
        idx_ok    = int'(s1_item_reg.weight_index) < N_INPUTS;
        rd_weight = '0;
        for (int k = 0; k < N_INPUTS; k++)
        begin
            if (int'(s1_item_reg.weight_index) == k)
            begin
                rd_weight = weight_reg[k];
            end
        end

        wval_w = WIDE_BITS'(s1_item_reg.weight_value);
        if (wval_w > W_MAX_W)
        begin
            wr_value = W_MAX;
        end
        else if (wval_w < W_MIN_W)
        begin
            wr_value = W_MIN;
        end
        else
        begin
            wr_value = WEIGHT_BITS'(wval_w);
        end

        rd_w = WIDE_BITS'(rd_weight);
    end

    // next state and result for the request leaving the request register
    always_comb
    begin
        for (int k = 0; k < N_INPUTS; k++)
        begin
            weight_next[k] = weight_reg[k];
        end

        // counter clear applies before the request itself
        match_base  = s1_item_reg.clear_counts ? '0 : match_cnt_reg;
        change_base = s1_item_reg.clear_counts ? '0 : change_cnt_reg;
        match_cnt_next  = match_base;
        change_cnt_next = change_base;

        out_sum_next     = '0;
        out_fired_next   = 1'b0;
        out_correct_next = 1'b0;
        out_updated_next = 1'b0;
        out_wout_next    = '0;

        unique case (s1_item_reg.op)
            OP_TRAIN:
            begin
                // reported sum clipped to the output field
                if (sum_c > SUM_MAX_C)
                begin
                    out_sum_next = SUM_OUT_BITS'(SUM_MAX_C);
                end
                else if (sum_c < SUM_MIN_C)
                begin
                    out_sum_next = SUM_OUT_BITS'(SUM_MIN_C);
                end
                else
                begin
                    out_sum_next = SUM_OUT_BITS'(sum_c);
                end
                out_fired_next   = fire_now;
                out_correct_next = !learn;
                out_updated_next = learn;

                if (!learn && match_base != COUNT_MAX)
                begin
                    match_cnt_next = match_base + 1'b1;
                end
                if (learn)
                begin
                    if (change_base != COUNT_MAX)
                    begin
                        change_cnt_next = change_base + 1'b1;
                    end
                    // nudge active weights toward the wanted answer, saturating
                    for (int k = 0; k < N_INPUTS; k++)
                    begin
                        if (pix_wide[k])
                        begin
                            if (positive)
                            begin
                                if (weight_reg[k] != W_MAX)
                                begin
                                    weight_next[k] = weight_reg[k] + WEIGHT_BITS'(1);
                                end
                            end
                            else
                            begin
                                if (weight_reg[k] != W_MIN)
                                begin
                                    weight_next[k] = weight_reg[k] - WEIGHT_BITS'(1);
                                end
                            end
                        end
                    end
                end
            end
            OP_WRITE:
            begin
                for (int k = 0; k < N_INPUTS; k++)
                begin
                    if (int'(s1_item_reg.weight_index) == k)
                    begin
                        weight_next[k] = wr_value;
                    end
                end
            end
            OP_READ:
            begin
                // out-of-range index reads as zero
                if (idx_ok)
                begin
                    if (rd_w > RD_MAX_W)
                    begin
                        out_wout_next = WVAL_BITS'(RD_MAX_W);
                    end
                    else if (rd_w < RD_MIN_W)
                    begin
                        out_wout_next = WVAL_BITS'(RD_MIN_W);
                    end
                    else
                    begin
                        out_wout_next = WVAL_BITS'(rd_w);
                    end
                end
            end
            OP_NOP:
            begin
                // counters only
            end
            default:
            begin
            end
        endcase
    end

    // neuron state, updated as the request moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N_INPUTS; k++)
            begin
                weight_reg[k] <= WEIGHT_BITS'(reset_weight(k));
            end
            match_cnt_reg  <= '0;
            change_cnt_reg <= '0;
        end
        else if (s1_fire)
        begin
            for (int k = 0; k < N_INPUTS; k++)
            begin
                weight_reg[k] <= weight_next[k];
            end
            match_cnt_reg  <= match_cnt_next;
            change_cnt_reg <= change_cnt_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_sum_reg     <= out_sum_next;
            out_fired_reg   <= out_fired_next;
            out_correct_reg <= out_correct_next;
            out_updated_reg <= out_updated_next;
            out_wout_reg    <= out_wout_next;
        end
    end

    // counters are part of the state, so the result shows them directly
    assign out_valid    = out_valid_reg;
    assign weighted_sum = out_sum_reg;
    assign fired        = out_fired_reg;
    assign correct      = out_correct_reg;
    assign updated      = out_updated_reg;
    assign match_total  = match_cnt_reg;
    assign change_total = change_cnt_reg;
    assign weight_out   = out_wout_reg;

`ifndef SYNTH
    // a request leaving the request register always lands in the result register
    a_fire_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("request lost between stages");

    // a full request stage behind a stalled result must hold off new requests
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && s1_valid_reg) |-> !in_ready)
        else $error("request accepted into a full stage");

    // a learning step never counts as a match
    a_learn_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_updated_reg && out_correct_reg))
        else $error("updated and correct both set");

    // without a clear the change counter holds or grows by one
    a_change_step: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !s1_item_reg.clear_counts) |=>
        (change_cnt_reg == $past(change_cnt_reg) ||
         change_cnt_reg == $past(change_cnt_reg) + 16'd1))
        else $error("change counter jumped");

    // without a clear the match counter never falls
    a_match_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !s1_item_reg.clear_counts) |=> match_cnt_reg >= $past(match_cnt_reg))
        else $error("match counter fell");
`endif

endmodule
